@@ hdl/tcofq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcofq_pkg
// Shared codes and types of the two-class oldest-first queue.
// ----------------------------------------------------------------------------
package tcofq_pkg;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_ENQ    = 2'd0;
  localparam logic [1:0] KIND_OLDEST = 2'd1;
  localparam logic [1:0] KIND_CLASS  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted operation
    logic commit;   // apply the operation and load the result register
  } ctrl_cmd_t;

endpackage

@@ hdl/tcofq_req_if.sv @@
// ----------------------------------------------------------------------------
// tcofq_req_if
// Operation channel: valid/ready handshake with the operation fields.
// ----------------------------------------------------------------------------
interface tcofq_req_if #(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic                    target_class;
  logic [PAYLOAD_BITS-1:0] new_payload;

  modport source (output valid, kind, target_class, new_payload, input ready);
  modport sink   (input valid, kind, target_class, new_payload, output ready);
endinterface

@@ hdl/tcofq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tcofq_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface tcofq_rsp_if #(
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic                    out_class;
  logic [PAYLOAD_BITS-1:0] out_payload;

  modport source (output valid, status, out_class, out_payload, input ready);
  modport sink   (input valid, status, out_class, out_payload, output ready);
endinterface

@@ hdl/two_class_oldest_first_queue_core.sv @@
// ----------------------------------------------------------------------------
// two_class_oldest_first_queue_core
// Two class FIFOs with shared arrival stamps and an oldest-first dequeue.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Modport  Fields
//  -------  ---  -------  ---------------------------------------------
//  req      in   sink     kind, target_class, new_payload
//  rsp      out  source   status, out_class, out_payload
//
//  Steps: the idle state takes an operation while both head entries are
//  read from RAM; the execute state compares stamps, updates the queue and
//  loads the result. A new operation is taken only after the last one has loaded its result.
//  Reset: synchronous; pointers, counts and the stamp clear at once, RAM
//  contents stay undefined and need no clearing pass.
//  Stalls: a waiting result holds in the output register; the next operation
//  is still taken and holds in execute until that register frees.
//
module two_class_oldest_first_queue_core
  import tcofq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int STAMP_BITS   = 8
) (
  input  logic       clk,
  input  logic       rst,
  tcofq_req_if.sink  req,
  tcofq_rsp_if.source rsp
);

  ctrl_cmd_t cmd;

  // controller: handshake on both sides, one operation in flight
  tcofq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // datapath: latch on capture, decide and update on commit
  tcofq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .STAMP_BITS   (STAMP_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .kind         (req.kind),
    .target_class (req.target_class),
    .new_payload  (req.new_payload),
    .status       (rsp.status),
    .out_class    (rsp.out_class),
    .out_payload  (rsp.out_payload)
  );

endmodule

@@ hdl/tcofq_ram.sv @@
// ----------------------------------------------------------------------------
// tcofq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcofq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tcofq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcofq_ctrl
// Controller: operation handshake, execute sequencing, result valid flag.
// ----------------------------------------------------------------------------
module tcofq_ctrl
  import tcofq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   rsp_free;

  // result register can take a new value this cycle
  assign rsp_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_EXEC;
      ST_EXEC: if (rsp_free)  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.commit = rsp_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/tcofq_dp.sv @@
// ----------------------------------------------------------------------------
// tcofq_dp
// Datapath: two queues in RAM, pointers, arrival stamp, head compare, result.
// ----------------------------------------------------------------------------
module tcofq_dp
  import tcofq_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 16,
  parameter int STAMP_BITS   = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ctrl_cmd_t               cmd,
  input  logic [1:0]              kind,
  input  logic                    target_class,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  output logic [1:0]              status,
  output logic                    out_class,
  output logic [PAYLOAD_BITS-1:0] out_payload
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = PAYLOAD_BITS + STAMP_BITS;

  // latched operation
  logic [1:0]              op_kind;
  logic                    op_class;
  logic [PAYLOAD_BITS-1:0] op_payload;

  logic [STAMP_BITS-1:0]   arrival;

  // per-class views
  logic [ENTRY_W-1:0]      head_entry [2];
  logic [1:0]              has_item;
  logic [1:0]              is_full;
  logic [1:0]              push;
  logic [1:0]              pop;

  // decision
  logic [STAMP_BITS-1:0]   stamp_diff;
  logic                    cat_older;
  logic                    take;
  logic [1:0]              status_d;
  logic                    class_d;
  logic [PAYLOAD_BITS-1:0] payload_d;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind    <= kind;
      op_class   <= target_class;
      op_payload <= new_payload;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_queue
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic [CNT_W-1:0] count;

    assign has_item[c] = count != '0;
    assign is_full[c]  = count == CNT_W'(QUEUE_DEPTH);

    tcofq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (cmd.commit && push[c]),
      .waddr (tail),
      .wdata ({op_payload, arrival}),
      .raddr (head),
      .rdata (head_entry[c])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end else if (cmd.commit) begin
        if (push[c]) begin
          tail  <= (tail == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
          count <= count + 1'b1;
        end else if (pop[c]) begin
          head  <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          count <= count - 1'b1;
        end
      end
    end
  end

  // cat head older when the modular difference has its top bit set; ties go to dog
  assign stamp_diff = head_entry[1][STAMP_BITS-1:0] - head_entry[0][STAMP_BITS-1:0];
  assign cat_older  = stamp_diff[STAMP_BITS-1];
  assign take       = !has_item[0] ? 1'b1 : (!has_item[1] ? 1'b0 : cat_older);

  always_comb begin
    status_d  = STATUS_OK;
    class_d   = op_class;
    payload_d = '0;
    push      = 2'b00;
    pop       = 2'b00;
    case (op_kind)
      KIND_ENQ: begin
        if (is_full[op_class]) begin
          status_d = STATUS_FULL;
        end else begin
          push[op_class] = 1'b1;
        end
      end
      KIND_OLDEST: begin
        class_d = 1'b0;
        if (has_item == 2'b00) begin
          status_d = STATUS_EMPTY;
        end else begin
          class_d   = take;
          pop[take] = 1'b1;
          payload_d = head_entry[take][ENTRY_W-1:STAMP_BITS];
        end
      end
      default: begin
        // named class dequeue, spare code included
        if (!has_item[op_class]) begin
          status_d = STATUS_EMPTY;
        end else begin
          pop[op_class] = 1'b1;
          payload_d     = head_entry[op_class][ENTRY_W-1:STAMP_BITS];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival <= '0;
    end else if (cmd.commit && push != 2'b00) begin
      arrival <= arrival + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= status_d;
      out_class   <= class_d;
      out_payload <= payload_d;
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class oldest-first queue core. A shadow
// pair of class queues with a shared arrival stamp predicts every result. A
// short directed opening covers the empty, spare-kind and oldest-pick
// cases. Random bursts of fills, drains, mixed traffic and one-class churn
// follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb
  import tcofq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int PW    = 16;
  localparam int SW    = 8;

  localparam int RANDOM_OPS  = 1900;
  localparam int CALM_FIRST  = 800;   // operation index where idling stops
  localparam int CALM_LAST   = 1100;  // operation index where idling resumes
  localparam int HOLD_START  = 1500;  // receiver cycle where the long hold-off begins
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 20;

  // Class codes carried in target_class and out_class
  localparam logic CLASS_DOG = 1'b0;
  localparam logic CLASS_CAT = 1'b1;

  typedef struct packed {
    logic [1:0]    status;
    logic          out_class;
    logic [PW-1:0] out_payload;
  } queue_result_t;

  // --------------------------------------------------------------------------
  // Shadow of both class queues. note_op runs the operation on the shadow and
  // queues the result it must produce; check_result compares a result from
  // the block against the oldest one still awaited.
  // --------------------------------------------------------------------------
  class twin_queue_shadow;
    logic [PW-1:0] payload_mem [2][DEPTH];
    logic [SW-1:0] stamp_mem   [2][DEPTH];
    int            head  [2];
    int            tail  [2];
    int            count [2];
    logic [SW-1:0] arrival;
    queue_result_t awaited_results [$];
    int            mismatch_count;

    function new();
      for (int c = 0; c < 2; c++) begin
        head[c]  = 0;
        tail[c]  = 0;
        count[c] = 0;
      end
      arrival        = '0;
      mismatch_count = 0;
    endfunction

    function logic [PW-1:0] pop_head(int c);
      logic [PW-1:0] p;
      p       = payload_mem[c][head[c]];
      head[c] = (head[c] + 1) % DEPTH;
      count[c]--;
      return p;
    endfunction

    function void note_op(logic [1:0] kind, logic cls, logic [PW-1:0] pay);
      queue_result_t r;
      logic [SW-1:0] age_gap;
      int            take;
      r.status      = STATUS_OK;
      r.out_class   = cls;
      r.out_payload = '0;
      case (kind)
        KIND_ENQ: begin
          if (count[cls] >= DEPTH) begin
            r.status = STATUS_FULL;
          end else begin
            payload_mem[cls][tail[cls]] = pay;
            stamp_mem[cls][tail[cls]]   = arrival;
            tail[cls] = (tail[cls] + 1) % DEPTH;
            count[cls]++;
            arrival = arrival + 1'b1;
          end
        end
        KIND_OLDEST: begin
          r.out_class = CLASS_DOG;
          if (count[0] == 0 && count[1] == 0) begin
            r.status = STATUS_EMPTY;
          end else begin
            if (count[1] == 0) begin
              take = 0;
            end else if (count[0] == 0) begin
              take = 1;
            end else begin
              // cat is older when its stamp lies behind the dog's, modulo wrap
              age_gap = stamp_mem[1][head[1]] - stamp_mem[0][head[0]];
              take    = age_gap[SW-1] ? 1 : 0;
            end
            r.out_class   = take[0];
            r.out_payload = pop_head(take);
          end
        end
        default: begin
          // named class dequeue; the spare kind behaves the same
          if (count[cls] == 0) r.status = STATUS_EMPTY;
          else r.out_payload = pop_head(cls);
        end
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic cls, logic [PW-1:0] pay);
      queue_result_t e;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d out_class %0d out_payload 0x%04h",
               status, cls, pay);
        mismatch_count++;
        return;
      end
      e = awaited_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, status);
        mismatch_count++;
      end
      if (cls !== e.out_class) begin
        $error("out_class: expected %0d actual %0d", e.out_class, cls);
        mismatch_count++;
      end
      if (pay !== e.out_payload) begin
        $error("out_payload: expected 0x%04h actual 0x%04h", e.out_payload, pay);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic calm;      // set while neither side may idle
  int   ops_sent;

  tcofq_req_if #(.PAYLOAD_BITS(PW)) req_ch ();
  tcofq_rsp_if #(.PAYLOAD_BITS(PW)) rsp_ch ();

  twin_queue_shadow shadow;

  two_class_oldest_first_queue_core #(
    .QUEUE_DEPTH  (DEPTH),
    .PAYLOAD_BITS (PW),
    .STAMP_BITS   (SW)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Sample both channels at the edge: note every accepted operation, check
  // every accepted result. A result can never belong to an operation taken
  // at the same edge, so the order of the two does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        shadow.note_op(req_ch.kind, req_ch.target_class, req_ch.new_payload);
      if (rsp_ch.valid && rsp_ch.ready)
        shadow.check_result(rsp_ch.status, rsp_ch.out_class, rsp_ch.out_payload);
    end
  end

  // Receiver: idle at random, hold off for one long stretch so the block
  // fills up and stalls its input, and never idle while calm is set.
  initial begin
    int cyc;
    cyc = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        rsp_ch.ready <= 1'b0;
      else if (calm)
        rsp_ch.ready <= 1'b1;
      else
        rsp_ch.ready <= ($urandom_range(0, 99) >= 22);
    end
  end

  // Mostly random payloads, with the all-zero and all-one patterns now and then
  function automatic logic [PW-1:0] pick_payload();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return PW'($urandom_range(0, (1 << PW) - 1));
    endcase
  endfunction

  // Offer one operation and hold it until the transfer; idle first at random
  task automatic send_op(logic [1:0] kind, logic cls, logic [PW-1:0] pay);
    calm = (ops_sent >= CALM_FIRST && ops_sent < CALM_LAST);
    while (!calm && $urandom_range(0, 99) < 22) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.target_class <= cls;
    req_ch.new_payload  <= pay;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ops_sent++;
  endtask

  initial begin
    int   burst;
    int   mode;
    int   len;
    logic cls;

    shadow   = new();
    calm     = 1'b0;
    ops_sent = 0;
    rst      = 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.kind         <= KIND_ENQ;
    req_ch.target_class <= CLASS_DOG;
    req_ch.new_payload  <= '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: dequeues of empty queues (both kinds of dequeue and
    // the spare kind), extreme payloads, oldest picks between both classes
    // and with only one class holding items.
    send_op(KIND_OLDEST, CLASS_DOG, '1);
    send_op(KIND_CLASS,  CLASS_DOG, '0);
    send_op(KIND_CLASS,  CLASS_CAT, '1);
    send_op(KIND_SPARE,  CLASS_CAT, '0);
    send_op(KIND_ENQ,    CLASS_DOG, '1);
    send_op(KIND_ENQ,    CLASS_CAT, '0);
    send_op(KIND_ENQ,    CLASS_CAT, '1);
    send_op(KIND_ENQ,    CLASS_DOG, '0);
    send_op(KIND_OLDEST, CLASS_CAT, '0);
    send_op(KIND_OLDEST, CLASS_DOG, '1);
    send_op(KIND_SPARE,  CLASS_CAT, '0);
    send_op(KIND_CLASS,  CLASS_DOG, '0);
    send_op(KIND_ENQ,    CLASS_CAT, 16'hA5A5);
    send_op(KIND_OLDEST, CLASS_DOG, '0);
    send_op(KIND_ENQ,    CLASS_DOG, 16'h5A5A);
    send_op(KIND_OLDEST, CLASS_CAT, '1);
    send_op(KIND_OLDEST, CLASS_CAT, '0);

    // Random bursts; the first two fill each class, past full when the burst runs long enough
    burst = 0;
    while (ops_sent < RANDOM_OPS) begin
      mode = (burst < 2) ? 0 : $urandom_range(0, 9);
      cls  = (burst < 2) ? burst[0] : 1'($urandom_range(0, 1));
      case (mode)
        0, 1: begin
          // fill one class, past full when the burst runs long enough
          len = $urandom_range(14, 20);
          repeat (len) send_op(KIND_ENQ, cls, pick_payload());
        end
        2, 3: begin
          // drain oldest-first, on to empty and beyond when the burst outlasts the queues
          len = $urandom_range(10, 36);
          repeat (len) send_op(KIND_OLDEST, 1'($urandom_range(0, 1)), pick_payload());
        end
        4, 5: begin
          // mix of enqueues (half of them), oldest-first and named-class dequeues
          len = $urandom_range(8, 24);
          repeat (len) begin
            case ($urandom_range(0, 3))
              0, 1:    send_op(KIND_ENQ, 1'($urandom_range(0, 1)), pick_payload());
              2:       send_op(KIND_OLDEST, 1'($urandom_range(0, 1)), pick_payload());
              default: send_op(KIND_CLASS, 1'($urandom_range(0, 1)), pick_payload());
            endcase
          end
        end
        6: begin
          // churn one class so the other head ages and the stamp wraps
          len = $urandom_range(20, 60);
          repeat (len) begin
            send_op(KIND_ENQ, cls, pick_payload());
            send_op(KIND_CLASS, cls, pick_payload());
          end
        end
        7: begin
          // noise: any kind, the spare one included
          len = 8;
          repeat (len) send_op(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               pick_payload());
        end
        default: begin
          // interleave both classes, then pick oldest-first
          len = $urandom_range(4, 12);
          repeat (len) send_op(KIND_ENQ, 1'($urandom_range(0, 1)), pick_payload());
          repeat (len) send_op(KIND_OLDEST, 1'($urandom_range(0, 1)), pick_payload());
        end
      endcase
      burst++;
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);

    // Wait out every awaited result, then give stray results a chance to show
    while (shadow.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
